FILE: hdl/wsfp_pkg.sv
`timescale 1ns / 1ps
package wsfp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OPCODE_W = 4;
  localparam int unsigned LEN_W = 64;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned CNT_W = 4;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [CNT_W-1:0] EXT16_BYTES = 4'd2;
  localparam logic [CNT_W-1:0] EXT64_BYTES = 4'd8;
  localparam logic [CNT_W-1:0] KEY_BYTES = 4'd4;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_MASK    = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   payload_byte;
    logic [OPCODE_W-1:0] frame_opcode;
    logic                final_fragment;
    logic                has_payload;
    logic                last_of_frame;
    logic [LEN_W-1:0]    payload_length;
  } result_t;

endpackage

FILE: hdl/wsfp_parse.sv
`timescale 1ns / 1ps
module wsfp_parse (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [wsfp_pkg::BYTE_W-1:0]  in_byte,
  output logic                         res_valid,
  output wsfp_pkg::result_t            res
);
  import wsfp_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic                 seen_r, seen_nxt;
  logic                 fin_r, fin_nxt;
  logic [OPCODE_W-1:0]  opcode_r, opcode_nxt;
  logic                 mask_p_r, mask_p_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [LEN_W-1:0]     left_r, left_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [1:0]           idx_r, idx_nxt;

  logic                 field_end;
  logic                 len_done;
  logic                 hdr_done;
  logic                 empty_frame;
  logic                 last_byte;
  logic [BYTE_W-1:0]    key_byte;
  logic [6:0]           code;

  assign code      = in_byte[6:0];
  assign field_end = (cnt_r == CNT_W'(1));
  assign last_byte = (left_r == LEN_W'(1));

  // header fields, length and key accumulation
  always_comb begin
    seen_nxt   = seen_r;
    fin_nxt    = fin_r;
    opcode_nxt = opcode_r;
    mask_p_nxt = mask_p_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    len_done   = 1'b0;
    unique case (phase_r)
      PH_HEADER: begin
        if (!seen_r) begin
          fin_nxt    = in_byte[7];
          opcode_nxt = in_byte[OPCODE_W-1:0];
          seen_nxt   = 1'b1;
        end else begin
          seen_nxt   = 1'b0;
          mask_p_nxt = in_byte[7];
          key_nxt    = '0;
          if (code < LEN_CODE_16) begin
            len_nxt  = LEN_W'(code);
            len_done = 1'b1;
          end else begin
            len_nxt = '0;
            cnt_nxt = (code == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;
          end
        end
      end
      PH_LENGTH: begin
        len_nxt  = {len_r[LEN_W-BYTE_W-1:0], in_byte};
        cnt_nxt  = cnt_r - CNT_W'(1);
        len_done = field_end;
      end
      PH_MASK: begin
        key_nxt = {key_r[KEY_W-BYTE_W-1:0], in_byte};
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      PH_PAYLOAD: begin
      end
      default: begin
      end
    endcase
    if (len_done && mask_p_nxt) begin
      cnt_nxt = KEY_BYTES;
    end
    // a header after an end-of-frame byte starts clean
    if (phase_r == PH_PAYLOAD && last_byte) begin
      seen_nxt = 1'b0;
    end
  end

  assign hdr_done    = (len_done && !mask_p_nxt) || (phase_r == PH_MASK && field_end);
  assign empty_frame = hdr_done && (len_nxt == '0);

  // phase sequencing
  always_comb begin
    phase_nxt = phase_r;
    priority if (phase_r == PH_PAYLOAD) begin
      if (last_byte) begin
        phase_nxt = PH_HEADER;
      end
    end else if (hdr_done) begin
      phase_nxt = empty_frame ? PH_HEADER : PH_PAYLOAD;
    end else if (len_done) begin
      phase_nxt = PH_MASK;
    end else if (phase_r == PH_HEADER && seen_r) begin
      phase_nxt = PH_LENGTH;
    end
  end

  always_comb begin
    unique case (idx_r)
      2'd0: key_byte = key_r[31:24];
      2'd1: key_byte = key_r[23:16];
      2'd2: key_byte = key_r[15:8];
      2'd3: key_byte = key_r[7:0];
      default: key_byte = '0;
    endcase
  end

  // payload counters and result
  always_comb begin
    left_nxt  = left_r;
    idx_nxt   = idx_r;
    res_valid = 1'b0;
    res.payload_byte   = '0;
    res.frame_opcode   = opcode_r;
    res.final_fragment = fin_r;
    res.has_payload    = 1'b0;
    res.last_of_frame  = 1'b1;
    res.payload_length = len_nxt;
    if (phase_r == PH_PAYLOAD) begin
      left_nxt          = left_r - LEN_W'(1);
      idx_nxt           = idx_r + 2'd1;
      res_valid         = accept;
      res.payload_byte  = in_byte ^ key_byte;
      res.has_payload   = 1'b1;
      res.last_of_frame = last_byte;
    end else if (hdr_done) begin
      idx_nxt = 2'd0;
      if (empty_frame) begin
        res_valid = accept;
      end else begin
        left_nxt = len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      seen_r   <= 1'b0;
      fin_r    <= 1'b0;
      opcode_r <= '0;
      mask_p_r <= 1'b0;
      len_r    <= '0;
      left_r   <= '0;
      cnt_r    <= '0;
      key_r    <= '0;
      idx_r    <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      seen_r   <= seen_nxt;
      fin_r    <= fin_nxt;
      opcode_r <= opcode_nxt;
      mask_p_r <= mask_p_nxt;
      len_r    <= len_nxt;
      left_r   <= left_nxt;
      cnt_r    <= cnt_nxt;
      key_r    <= key_nxt;
      idx_r    <= idx_nxt;
    end
  end

endmodule

FILE: hdl/wsfp_out_reg.sv
`timescale 1ns / 1ps
module wsfp_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  wsfp_pkg::result_t  res,
  input  logic               out_stall,
  output logic               full_blocked,
  output logic               out_valid,
  output wsfp_pkg::result_t  out_res
);
  import wsfp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  // the register may be refilled in the cycle its beat leaves
  assign full_blocked = valid_r && out_stall;

  always_comb begin
    valid_nxt = valid_r;
    priority if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

FILE: hdl/websocket_frame_parser.sv
`timescale 1ns / 1ps
// websocket frame parser: takes a raw frame stream one byte per beat on the in_ channel
// and returns unmasked payload bytes on the out_ channel, each tagged with opcode, fin bit,
// decoded frame length and a last-of-frame marker. header, extended length and mask key
// bytes produce no output beat; a zero-length frame produces one beat with has_payload low
// on the byte that completes its header.
// throughput: one input byte per clock cycle while in_stall is low.
// a result is registered at the edge that accepts the byte causing it and appears on the
// out_ channel in the cycle after; parse state and the result are updated in the same edge.
// the single output register is refilled in the cycle its beat is taken, so in_stall is
// high only while a result is held and out_stall is high.
// reset (rst_n low, synchronous) returns the parser to the start of a frame header and
// drops any held result.
// while the receiver stalls, the held beat stays unchanged on the out_ ports.
module websocket_frame_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [wsfp_pkg::BYTE_W-1:0]     in_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [wsfp_pkg::BYTE_W-1:0]     out_payload_byte,
  output logic [wsfp_pkg::OPCODE_W-1:0]   out_frame_opcode,
  output logic                            out_final_fragment,
  output logic                            out_has_payload,
  output logic                            out_last_of_frame,
  output logic [wsfp_pkg::LEN_W-1:0]      out_payload_length
);
  import wsfp_pkg::*;

  logic    accept;
  logic    res_valid;
  logic    blocked;
  result_t res;
  result_t out_res;

  assign in_stall = blocked;
  assign accept   = in_valid && !blocked;

  wsfp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  wsfp_out_reg u_out_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (res_valid),
    .res          (res),
    .out_stall    (out_stall),
    .full_blocked (blocked),
    .out_valid    (out_valid),
    .out_res      (out_res)
  );

  assign out_payload_byte   = out_res.payload_byte;
  assign out_frame_opcode   = out_res.frame_opcode;
  assign out_final_fragment = out_res.final_fragment;
  assign out_has_payload    = out_res.has_payload;
  assign out_last_of_frame  = out_res.last_of_frame;
  assign out_payload_length = out_res.payload_length;

endmodule

FILE: tb/websocket_frame_checker.sv
`timescale 1ns / 1ps
module websocket_frame_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [wsfp_pkg::BYTE_W-1:0]   in_byte,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [wsfp_pkg::BYTE_W-1:0]   out_payload_byte,
  input  logic [wsfp_pkg::OPCODE_W-1:0] out_frame_opcode,
  input  logic                          out_final_fragment,
  input  logic                          out_has_payload,
  input  logic                          out_last_of_frame,
  input  logic [wsfp_pkg::LEN_W-1:0]    out_payload_length,
  output int                            fail_count,
  output int                            expected_left,
  output int                            beats_checked
);
  import wsfp_pkg::*;

  // parser state as the stream has been seen so far
  phase_t              phase;
  logic                hdr_seen;
  logic                fin;
  logic [OPCODE_W-1:0] opcode;
  logic                mask_on;
  logic [LEN_W-1:0]    frame_len;
  logic [LEN_W-1:0]    remaining;
  logic [CNT_W-1:0]    field_left;
  logic [KEY_W-1:0]    key;
  logic [1:0]          key_idx;

  result_t expected_beats[$];

  function automatic bit header_complete(output result_t r);
    r = '0;
    key_idx = '0;
    if (frame_len == '0) begin
      // empty frame: one marker beat, back to header
      phase = PH_HEADER;
      hdr_seen = 1'b0;
      r.frame_opcode = opcode;
      r.final_fragment = fin;
      r.last_of_frame = 1'b1;
      return 1'b1;
    end
    remaining = frame_len;
    phase = PH_PAYLOAD;
    return 1'b0;
  endfunction

  function automatic bit length_complete(output result_t r);
    r = '0;
    if (mask_on) begin
      field_left = KEY_BYTES;
      phase = PH_MASK;
      return 1'b0;
    end
    return header_complete(r);
  endfunction

  function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output result_t r);
    logic [BYTE_W-1:0] key_byte;
    r = '0;
    case (phase)
      PH_HEADER: begin
        if (!hdr_seen) begin
          fin = b[7];
          opcode = b[OPCODE_W-1:0];
          hdr_seen = 1'b1;
          return 1'b0;
        end
        hdr_seen = 1'b0;
        mask_on = b[7];
        key = '0;
        if (b[6:0] < LEN_CODE_16) begin
          frame_len = LEN_W'(b[6:0]);
          return length_complete(r);
        end
        frame_len = '0;
        field_left = (b[6:0] == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;
        phase = PH_LENGTH;
        return 1'b0;
      end
      PH_LENGTH: begin
        frame_len = {frame_len[LEN_W-BYTE_W-1:0], b};
        field_left = field_left - CNT_W'(1);
        if (field_left == '0) return length_complete(r);
        return 1'b0;
      end
      PH_MASK: begin
        key = {key[KEY_W-BYTE_W-1:0], b};
        field_left = field_left - CNT_W'(1);
        if (field_left == '0) return header_complete(r);
        return 1'b0;
      end
      default: begin
        // key bytes rotate from the most significant one
        key_byte = key[8 * (3 - int'(key_idx)) +: 8];
        key_idx = key_idx + 2'd1;
        remaining = remaining - LEN_W'(1);
        r.payload_byte = b ^ key_byte;
        r.frame_opcode = opcode;
        r.final_fragment = fin;
        r.has_payload = 1'b1;
        r.last_of_frame = (remaining == '0);
        r.payload_length = frame_len;
        if (remaining == '0) begin
          phase = PH_HEADER;
          hdr_seen = 1'b0;
        end
        return 1'b1;
      end
    endcase
  endfunction

  // sampled mid-cycle: inputs change only at the rising edge
  always @(negedge clk) begin
    result_t got;
    result_t want;
    result_t beat;
    if (!rst_n) begin
      phase = PH_HEADER;
      hdr_seen = 1'b0;
      fin = 1'b0;
      opcode = '0;
      mask_on = 1'b0;
      frame_len = '0;
      remaining = '0;
      field_left = '0;
      key = '0;
      key_idx = '0;
      fail_count = 0;
      beats_checked = 0;
      expected_beats.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{payload_byte: out_payload_byte, frame_opcode: out_frame_opcode,
                final_fragment: out_final_fragment, has_payload: out_has_payload,
                last_of_frame: out_last_of_frame, payload_length: out_payload_length};
        if (expected_beats.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: beat with nothing expected: byte %02h op %h len %0d",
                     $realtime, got.payload_byte, got.frame_opcode, got.payload_length);
        end else begin
          want = expected_beats.pop_front();
          beats_checked++;
          if (got.payload_byte !== want.payload_byte ||
              got.frame_opcode !== want.frame_opcode ||
              got.final_fragment !== want.final_fragment ||
              got.has_payload !== want.has_payload ||
              got.last_of_frame !== want.last_of_frame ||
              got.payload_length !== want.payload_length) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: beat %0d mismatch", $realtime, beats_checked);
              $display("  expected byte %02h op %h fin %b has %b last %b len %0h",
                       want.payload_byte, want.frame_opcode, want.final_fragment,
                       want.has_payload, want.last_of_frame, want.payload_length);
              $display("  actual   byte %02h op %h fin %b has %b last %b len %0h",
                       got.payload_byte, got.frame_opcode, got.final_fragment,
                       got.has_payload, got.last_of_frame, got.payload_length);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (parse_byte(in_byte, beat)) expected_beats = {expected_beats, beat};
      end
    end
    expected_left = expected_beats.size();
  end

endmodule

FILE: tb/websocket_frame_parser_test.sv
`timescale 1ns / 1ps
module websocket_frame_parser_test;
  import wsfp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int STREAM_TARGET = 1000;

  typedef enum {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [BYTE_W-1:0]   in_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [BYTE_W-1:0]   out_payload_byte;
  logic [OPCODE_W-1:0] out_frame_opcode;
  logic                out_final_fragment;
  logic                out_has_payload;
  logic                out_last_of_frame;
  logic [LEN_W-1:0]    out_payload_length;

  int fail_count;
  int expected_left;
  int beats_checked;

  logic [BYTE_W-1:0] stream_q[$];
  int frame_total = 0;
  int cycle_count = 0;

  // calm and hold_requests are shared between sender and receiver; all written with nonblocking at the edge
  logic calm = 1'b0;
  int   hold_requests = 0;
  int   hold_served = 0;
  int   hold_left = 0;

  always #5 clk = ~clk;

  websocket_frame_parser DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_payload_byte(out_payload_byte), .out_frame_opcode(out_frame_opcode),
    .out_final_fragment(out_final_fragment), .out_has_payload(out_has_payload),
    .out_last_of_frame(out_last_of_frame), .out_payload_length(out_payload_length)
  );

  websocket_frame_checker frame_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_payload_byte(out_payload_byte), .out_frame_opcode(out_frame_opcode),
    .out_final_fragment(out_final_fragment), .out_has_payload(out_has_payload),
    .out_last_of_frame(out_last_of_frame), .out_payload_length(out_payload_length),
    .fail_count(fail_count), .expected_left(expected_left),
    .beats_checked(beats_checked)
  );

  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    stream_q = {stream_q, b};
  endtask

  task automatic add_frame(input logic fin, input logic [2:0] rsv,
                           input logic [OPCODE_W-1:0] op, input logic masked,
                           input len_form_t form, input logic [LEN_W-1:0] len,
                           input int body_bytes);
    logic [KEY_W-1:0] key;
    int ext_bytes;
    key = $urandom;
    queue_byte({fin, rsv, op});
    case (form)
      LEN_SHORT: begin
        queue_byte({masked, len[6:0]});
        ext_bytes = 0;
      end
      LEN_EXT16: begin
        queue_byte({masked, LEN_CODE_16});
        ext_bytes = 2;
      end
      default: begin
        queue_byte({masked, LEN_CODE_64});
        ext_bytes = 8;
      end
    endcase
    for (int k = ext_bytes - 1; k >= 0; k--) queue_byte(len[8 * k +: 8]);
    if (masked) begin
      for (int k = 3; k >= 0; k--) queue_byte(key[8 * k +: 8]);
    end
    for (int k = 0; k < body_bytes; k++) queue_byte(8'($urandom_range(0, 255)));
    frame_total++;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 32);
    end
  end

  initial begin
    int directed_bytes;
    int pick;
    int len;
    logic masked;
    len_form_t form;

    // empty frame, all-zero header, no key
    add_frame(1'b0, 3'b000, 4'h0, 1'b0, LEN_SHORT, 0, 0);
    // empty frame with key, reserved bits and top opcode set
    add_frame(1'b1, 3'b111, 4'hF, 1'b1, LEN_SHORT, 0, 0);
    // unmasked bytes pass straight through
    add_frame(1'b1, 3'b000, 4'h1, 1'b0, LEN_SHORT, 2, 2);
    // non-minimal 16-bit length with key
    add_frame(1'b0, 3'b010, 4'h2, 1'b1, LEN_EXT16, 1, 1);
    // 64-bit form carrying zero
    add_frame(1'b1, 3'b000, 4'hA, 1'b0, LEN_EXT64, 0, 0);
    directed_bytes = stream_q.size();

    while (stream_q.size() < directed_bytes + STREAM_TARGET) begin
      pick = $urandom_range(0, 99);
      masked = ($urandom_range(0, 99) < 60);
      if (pick < 78) begin
        form = LEN_SHORT;
        len = (pick < 4) ? 125 : $urandom_range(0, 12);
      end else if (pick < 92) begin
        form = LEN_EXT16;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(126, 300) : $urandom_range(0, 40);
      end else begin
        form = LEN_EXT64;
        len = $urandom_range(0, 20);
      end
      add_frame(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                4'($urandom_range(0, 15)), masked, form, LEN_W'(len), len);
    end
    // closing frame: every length bit set, stream stops inside its payload
    add_frame(1'b1, 3'b000, 4'h2, 1'b1, LEN_EXT64, '1, 9);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stream_q[i]) begin
      if (i == directed_bytes) begin
        // drain everything before the random part
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0) @(posedge clk);
      end
      if (i == directed_bytes + 200) hold_requests <= hold_requests + 1;
      calm <= (i >= directed_bytes + 400 && i < directed_bytes + 650);
      if (!(i >= directed_bytes + 400 && i < directed_bytes + 650) &&
          $urandom_range(0, 99) < 32) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      send_byte(stream_q[i]);
    end
    in_valid <= 1'b0;
    calm <= 1'b0;

    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d stream bytes in %0d frames, %0d output beats checked",
             stream_q.size(), frame_total, beats_checked);
    $display("with empty, masked, 16/64-bit length frames, a long output hold and a drain");
    if (fail_count == 0 && expected_left == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
